### rtl/core/assert_macros.svh
// assertion macros for the rtl of the quaternion unit
// no dependencies; the macros expand to nothing when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QAU_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define QAU_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define QAU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define QAU_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define QAU_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define QAU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### rtl/core/qau_pkg.sv
// types and fixed constants of the quaternion arithmetic unit
// no dependencies; imported by quaternion_arithmetic_unit, qau_checker and tb_top
package qau_pkg;

    // operation code width, carried in the slave tuser
    localparam int CMD_W   = 3;
    // multiplier lanes in the first stage
    localparam int LANES   = 16;
    // rotation matrix coefficients
    localparam int N_COEF  = 9;

    typedef enum logic [CMD_W-1:0] {
        CMD_MUL   = 3'd0,
        CMD_ROT   = 3'd1,
        CMD_ADD   = 3'd2,
        CMD_SUB   = 3'd3,
        CMD_NEG   = 3'd4,
        CMD_CONJ  = 3'd5,
        CMD_SCALE = 3'd6,
        CMD_DOT   = 3'd7
    } t_cmd;

endpackage

### rtl/core/quaternion_arithmetic_unit.sv
// an item passes from acceptance to o_m_axis_tvalid through four register stages
// (operand multiply, sum/round/clamp, rotation multiply, rotation sum/round/clamp)
// throughput: one item per cycle; every stage holds its item while the next is full and held
// reset: synchronous, active low; clears the valid bit of every stage, payload is not reset
// depends on qau_pkg and assert_macros.svh
`include "assert_macros.svh"

module quaternion_arithmetic_unit
    import qau_pkg::*;
#(
    parameter int FRAC_BITS  = 14,
    parameter int COMP_WIDTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scale_factor
    input  logic [((9*COMP_WIDTH+7)/8)*8-1:0]       i_s_axis_tdata,
    // command
    input  logic [CMD_W-1:0]                        i_s_axis_tuser,
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    // r_x, r_y, r_z, r_w
    output logic [((4*COMP_WIDTH+7)/8)*8-1:0]       o_m_axis_tdata,
    // saturated
    output logic                                    o_m_axis_tuser
);

    localparam int W   = COMP_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int PW  = 2 * W;
    localparam int CW  = W + 2;
    localparam int CVW = CW + W;
    localparam int AW  = ((2 * W > 2 * F + 1) ? 2 * W : 2 * F + 1) + 4;
    localparam int TDO = ((4 * COMP_WIDTH + 7) / 8) * 8;

    localparam logic signed [AW-1:0] CMAX_A     = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [AW-1:0] CMIN_A     = ~CMAX_A;
    localparam logic signed [AW-1:0] COEF_MAX_A = {{(AW-W){1'b0}}, {W{1'b1}}};
    localparam logic signed [AW-1:0] COEF_MIN_A = -COEF_MAX_A;
    localparam logic signed [AW-1:0] HALF_A     = {{(AW-1){1'b0}}, 1'b1} << (F - 1);
    localparam logic signed [AW-1:0] ONE_A      = {{(AW-1){1'b0}}, 1'b1} << (2 * F);

    // round to nearest, ties up, dropping the fraction bits
    function automatic logic signed [AW-1:0] rnd(input logic signed [AW-1:0] v);
        return (v + HALF_A) >>> F;
    endfunction

    // clamp to the component range, flag in the top bit
    function automatic logic [W:0] sat_res(input logic signed [AW-1:0] v);
        logic [W:0] res;
        if (v > CMAX_A) begin
            res = {1'b1, CMAX_A[W-1:0]};
        end else if (v < CMIN_A) begin
            res = {1'b1, CMIN_A[W-1:0]};
        end else begin
            res = {1'b0, v[W-1:0]};
        end
        return res;
    endfunction

    // clamp to the coefficient range, flag in the top bit
    function automatic logic [CW:0] sat_coef(input logic signed [AW-1:0] v);
        logic [CW:0] res;
        if (v > COEF_MAX_A) begin
            res = {1'b1, COEF_MAX_A[CW-1:0]};
        end else if (v < COEF_MIN_A) begin
            res = {1'b1, COEF_MIN_A[CW-1:0]};
        end else begin
            res = {1'b0, v[CW-1:0]};
        end
        return res;
    endfunction

    // stage handshake
    logic s1_en, s2_en, s3_en, s4_en;
    logic r_v1, r_v2, r_v3, r_v4;

    // input unpacking
    t_cmd                  s_cmd;
    logic signed [W-1:0]   s_a [4];
    logic signed [W-1:0]   s_b [4];
    logic signed [W-1:0]   s_s;

    // stage 1
    logic signed [W-1:0]   n_ma [LANES];
    logic signed [W-1:0]   n_mb [LANES];
    logic signed [PW-1:0]  n_p1 [LANES];
    logic signed [W-1:0]   n_simp1 [4];
    logic                  n_ssat1;
    logic [W:0]            w_sat1 [4];
    t_cmd                  r_cmd1;
    logic signed [PW-1:0]  r_p1 [LANES];
    logic signed [W-1:0]   r_simp1 [4];
    logic                  r_ssat1;
    logic signed [W-1:0]   r_vec1 [3];

    // stage 2
    logic signed [AW-1:0]  w_sum2 [4];
    logic [W:0]            w_res2 [4];
    logic signed [AW-1:0]  w_csum2 [N_COEF];
    logic [CW:0]           w_coef2 [N_COEF];
    logic signed [W-1:0]   n_res2 [4];
    logic                  n_sat2;
    logic signed [CW-1:0]  n_coef2 [N_COEF];
    logic                  n_csat2;
    t_cmd                  r_cmd2;
    logic signed [W-1:0]   r_res2 [4];
    logic                  r_sat2;
    logic signed [CW-1:0]  r_coef2 [N_COEF];
    logic                  r_csat2;
    logic signed [W-1:0]   r_vec2 [3];

    // stage 3
    logic signed [CVW-1:0] n_cv3 [N_COEF];
    t_cmd                  r_cmd3;
    logic signed [W-1:0]   r_res3 [4];
    logic                  r_sat3;
    logic                  r_csat3;
    logic signed [CVW-1:0] r_cv3 [N_COEF];

    // stage 4, output register
    logic [W:0]            w_rot4 [3];
    logic signed [W-1:0]   n_res4 [4];
    logic                  n_sat4;
    t_cmd                  r_cmd4;
    logic signed [W-1:0]   r_res4 [4];
    logic                  r_sat4;

    // each stage advances when empty or when the next one advances
    assign s4_en = !r_v4 || i_m_axis_tready;
    assign s3_en = !r_v3 || s4_en;
    assign s2_en = !r_v2 || s3_en;
    assign s1_en = !r_v1 || s2_en;
    assign o_s_axis_tready = s1_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (s1_en) r_v1 <= i_s_axis_tvalid;
            if (s2_en) r_v2 <= r_v1;
            if (s3_en) r_v3 <= r_v2;
            if (s4_en) r_v4 <= r_v3;
        end
    end

    // unpack the slave item
    always_comb begin
        s_cmd = t_cmd'(i_s_axis_tuser);
        for (int k = 0; k < 4; k++) begin
            s_a[k] = i_s_axis_tdata[k*W +: W];
            s_b[k] = i_s_axis_tdata[(k+4)*W +: W];
        end
        s_s = i_s_axis_tdata[8*W +: W];
    end

    // operand selection for the sixteen multiplier lanes
    always_comb begin
        // hamilton product terms, one row of four per result component
        n_ma[0]  = s_a[0]; n_mb[0]  = s_b[3];
        n_ma[1]  = s_b[0]; n_mb[1]  = s_a[3];
        n_ma[2]  = s_a[1]; n_mb[2]  = s_b[2];
        n_ma[3]  = s_a[2]; n_mb[3]  = s_b[1];
        n_ma[4]  = s_a[1]; n_mb[4]  = s_b[3];
        n_ma[5]  = s_b[1]; n_mb[5]  = s_a[3];
        n_ma[6]  = s_a[2]; n_mb[6]  = s_b[0];
        n_ma[7]  = s_a[0]; n_mb[7]  = s_b[2];
        n_ma[8]  = s_a[2]; n_mb[8]  = s_b[3];
        n_ma[9]  = s_b[2]; n_mb[9]  = s_a[3];
        n_ma[10] = s_a[0]; n_mb[10] = s_b[1];
        n_ma[11] = s_a[1]; n_mb[11] = s_b[0];
        n_ma[12] = s_a[3]; n_mb[12] = s_b[3];
        n_ma[13] = s_a[0]; n_mb[13] = s_b[0];
        n_ma[14] = s_a[1]; n_mb[14] = s_b[1];
        n_ma[15] = s_a[2]; n_mb[15] = s_b[2];
        case (s_cmd)
            CMD_ROT: begin
                for (int i = 0; i < LANES; i++) begin
                    n_ma[i] = '0;
                    n_mb[i] = '0;
                end
                // xx, yy, zz, xy, xz, yz, wx, wy, wz
                n_ma[0] = s_a[0]; n_mb[0] = s_a[0];
                n_ma[1] = s_a[1]; n_mb[1] = s_a[1];
                n_ma[2] = s_a[2]; n_mb[2] = s_a[2];
                n_ma[3] = s_a[0]; n_mb[3] = s_a[1];
                n_ma[4] = s_a[0]; n_mb[4] = s_a[2];
                n_ma[5] = s_a[1]; n_mb[5] = s_a[2];
                n_ma[6] = s_a[3]; n_mb[6] = s_a[0];
                n_ma[7] = s_a[3]; n_mb[7] = s_a[1];
                n_ma[8] = s_a[3]; n_mb[8] = s_a[2];
            end
            CMD_SCALE: begin
                for (int i = 0; i < LANES; i++) begin
                    n_ma[i] = '0;
                    n_mb[i] = '0;
                end
                for (int k = 0; k < 4; k++) begin
                    n_ma[4*k] = s_a[k];
                    n_mb[4*k] = s_s;
                end
            end
            default: begin
            end
        endcase
        for (int i = 0; i < LANES; i++) begin
            n_p1[i] = n_ma[i] * n_mb[i];
        end
    end

    // add, subtract, negate and conjugate finish in the first stage
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_sat1[k] = '0;
        end
        case (s_cmd)
            CMD_ADD: begin
                for (int k = 0; k < 4; k++) begin
                    w_sat1[k] = sat_res(AW'(s_a[k]) + AW'(s_b[k]));
                end
            end
            CMD_SUB: begin
                for (int k = 0; k < 4; k++) begin
                    w_sat1[k] = sat_res(AW'(s_a[k]) - AW'(s_b[k]));
                end
            end
            CMD_NEG: begin
                for (int k = 0; k < 4; k++) begin
                    w_sat1[k] = sat_res(-AW'(s_a[k]));
                end
            end
            CMD_CONJ: begin
                for (int k = 0; k < 3; k++) begin
                    w_sat1[k] = sat_res(-AW'(s_a[k]));
                end
                w_sat1[3] = {1'b0, s_a[3]};
            end
            default: begin
            end
        endcase
        n_ssat1 = 1'b0;
        for (int k = 0; k < 4; k++) begin
            n_simp1[k] = w_sat1[k][W-1:0];
            n_ssat1    = n_ssat1 | w_sat1[k][W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            r_cmd1  <= s_cmd;
            r_p1    <= n_p1;
            r_simp1 <= n_simp1;
            r_ssat1 <= n_ssat1;
            for (int k = 0; k < 3; k++) begin
                r_vec1[k] <= s_b[k];
            end
        end
    end

    // stage 2: sums of products for multiply, dot and scale
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_sum2[k] = '0;
        end
        case (r_cmd1)
            CMD_MUL: begin
                for (int k = 0; k < 3; k++) begin
                    w_sum2[k] = AW'(r_p1[4*k]) + AW'(r_p1[4*k+1])
                              + AW'(r_p1[4*k+2]) - AW'(r_p1[4*k+3]);
                end
                w_sum2[3] = AW'(r_p1[12]) - AW'(r_p1[13])
                          - AW'(r_p1[14]) - AW'(r_p1[15]);
            end
            CMD_DOT: begin
                w_sum2[3] = AW'(r_p1[12]) + AW'(r_p1[13])
                          + AW'(r_p1[14]) + AW'(r_p1[15]);
            end
            CMD_SCALE: begin
                for (int k = 0; k < 4; k++) begin
                    w_sum2[k] = AW'(r_p1[4*k]);
                end
            end
            default: begin
            end
        endcase
        for (int k = 0; k < 4; k++) begin
            w_res2[k] = sat_res(rnd(w_sum2[k]));
        end
    end

    // stage 2: rotation matrix coefficients from the products of a
    always_comb begin
        w_csum2[0] = ONE_A - (AW'(r_p1[1]) <<< 1) - (AW'(r_p1[2]) <<< 1);
        w_csum2[1] = (AW'(r_p1[3]) <<< 1) - (AW'(r_p1[8]) <<< 1);
        w_csum2[2] = (AW'(r_p1[4]) <<< 1) + (AW'(r_p1[7]) <<< 1);
        w_csum2[3] = (AW'(r_p1[3]) <<< 1) + (AW'(r_p1[8]) <<< 1);
        w_csum2[4] = ONE_A - (AW'(r_p1[0]) <<< 1) - (AW'(r_p1[2]) <<< 1);
        w_csum2[5] = (AW'(r_p1[5]) <<< 1) - (AW'(r_p1[6]) <<< 1);
        w_csum2[6] = (AW'(r_p1[4]) <<< 1) - (AW'(r_p1[7]) <<< 1);
        w_csum2[7] = (AW'(r_p1[5]) <<< 1) + (AW'(r_p1[6]) <<< 1);
        w_csum2[8] = ONE_A - (AW'(r_p1[0]) <<< 1) - (AW'(r_p1[1]) <<< 1);
        n_csat2 = 1'b0;
        for (int i = 0; i < N_COEF; i++) begin
            w_coef2[i] = sat_coef(rnd(w_csum2[i]));
            n_coef2[i] = w_coef2[i][CW-1:0];
            n_csat2    = n_csat2 | w_coef2[i][CW];
        end
        // coefficient clamps count for rotate only
        n_csat2 = n_csat2 && (r_cmd1 == CMD_ROT);
    end

    // stage 2: pick the finished result of the non-rotate operations
    always_comb begin
        n_sat2 = 1'b0;
        for (int k = 0; k < 4; k++) begin
            n_res2[k] = r_simp1[k];
        end
        case (r_cmd1) inside
            CMD_MUL, CMD_DOT, CMD_SCALE: begin
                for (int k = 0; k < 4; k++) begin
                    n_res2[k] = w_res2[k][W-1:0];
                    n_sat2    = n_sat2 | w_res2[k][W];
                end
            end
            CMD_ROT: begin
                for (int k = 0; k < 4; k++) begin
                    n_res2[k] = '0;
                end
            end
            default: begin
                n_sat2 = r_ssat1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s2_en) begin
            r_cmd2  <= r_cmd1;
            r_res2  <= n_res2;
            r_sat2  <= n_sat2;
            r_coef2 <= n_coef2;
            r_csat2 <= n_csat2;
            r_vec2  <= r_vec1;
        end
    end

    // stage 3: coefficient times vector component products
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_cv3[r*3+c] = r_coef2[r*3+c] * r_vec2[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_en) begin
            r_cmd3  <= r_cmd2;
            r_res3  <= r_res2;
            r_sat3  <= r_sat2;
            r_csat3 <= r_csat2;
            r_cv3   <= n_cv3;
        end
    end

    // stage 4: rotated vector rows, rounded and clamped
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_rot4[k] = sat_res(rnd(AW'(r_cv3[3*k]) + AW'(r_cv3[3*k+1])
                                    + AW'(r_cv3[3*k+2])));
        end
        n_res4 = r_res3;
        n_sat4 = r_sat3;
        if (r_cmd3 == CMD_ROT) begin
            n_sat4 = r_csat3;
            for (int k = 0; k < 3; k++) begin
                n_res4[k] = w_rot4[k][W-1:0];
                n_sat4    = n_sat4 | w_rot4[k][W];
            end
            n_res4[3] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s4_en) begin
            r_cmd4 <= r_cmd3;
            r_res4 <= n_res4;
            r_sat4 <= n_sat4;
        end
    end

    // master side
    assign o_m_axis_tvalid = r_v4;
    assign o_m_axis_tdata  = TDO'({r_res4[3], r_res4[2], r_res4[1], r_res4[0]});
    assign o_m_axis_tuser  = r_sat4;

    // checks
    `QAU_ASSERT_IMPL(a_rot_w_zero, i_clk, i_rst_n,
        r_v4 && (r_cmd4 == CMD_ROT), r_res4[3] == '0, "rotate item with nonzero w")
    `QAU_ASSERT_IMPL(a_dot_vec_zero, i_clk, i_rst_n, r_v4 && (r_cmd4 == CMD_DOT),
        (r_res4[0] == '0) && (r_res4[1] == '0) && (r_res4[2] == '0),
        "dot item with nonzero vector part")
    `QAU_ASSERT_IMPL(a_csat_rot_only, i_clk, i_rst_n, r_v3 && (r_cmd3 != CMD_ROT),
        !r_csat3, "coefficient clamp flagged outside rotate")
    `QAU_ASSERT_NEXT(a_s2_hold, i_clk, i_rst_n, r_v2 && !s3_en,
        r_v2 && $stable(r_cmd2) && $stable(r_sat2), "stalled stage two item changed")
    `QAU_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready,
        r_v1, "accepted item missing from stage one")

endmodule

### tb/qau_checker.sv
// checker for the quaternion arithmetic unit: predicts every accepted item and compares results
// depends on qau_pkg for the operation codes; instantiated by tb_top beside the block
`timescale 1ns / 100ps

module qau_checker
    import qau_pkg::*;
#(
    parameter int FRAC_BITS  = 14,
    parameter int COMP_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    input  logic                                i_s_axis_tready,
    // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scale_factor
    input  logic [((9*COMP_WIDTH+7)/8)*8-1:0]   i_s_axis_tdata,
    // command
    input  logic [CMD_W-1:0]                    i_s_axis_tuser,
    input  logic                                i_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // r_x, r_y, r_z, r_w
    input  logic [((4*COMP_WIDTH+7)/8)*8-1:0]   i_m_axis_tdata,
    // saturated
    input  logic                                i_m_axis_tuser,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    localparam longint CMAX     = (longint'(1) << (COMP_WIDTH - 1)) - 1;
    localparam longint CMIN     = -CMAX - 1;
    localparam longint COEF_MAX = (longint'(1) << COMP_WIDTH) - 1;
    localparam longint HALF     = longint'(1) << (FRAC_BITS - 1);
    // one at product scale, two fraction fields deep
    localparam longint ONE_SQ   = longint'(1) << (2 * FRAC_BITS);

    // operand item, a_x in the lowest bits
    typedef struct packed {
        logic signed [COMP_WIDTH-1:0] scale_factor;
        logic signed [COMP_WIDTH-1:0] b_w;
        logic signed [COMP_WIDTH-1:0] b_z;
        logic signed [COMP_WIDTH-1:0] b_y;
        logic signed [COMP_WIDTH-1:0] b_x;
        logic signed [COMP_WIDTH-1:0] a_w;
        logic signed [COMP_WIDTH-1:0] a_z;
        logic signed [COMP_WIDTH-1:0] a_y;
        logic signed [COMP_WIDTH-1:0] a_x;
    } t_operands;

    // result item with the saturation flag on top
    typedef struct packed {
        logic                         sat;
        logic signed [COMP_WIDTH-1:0] r_w;
        logic signed [COMP_WIDTH-1:0] r_z;
        logic signed [COMP_WIDTH-1:0] r_y;
        logic signed [COMP_WIDTH-1:0] r_x;
    } t_quat_result;

    t_quat_result pending_results [$];
    t_quat_result exp_res;
    t_quat_result got_res;
    int           fail_count = 0;
    int           pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    // round to nearest, ties upward, from product scale
    function automatic longint round_prod(longint v);
        return (v + HALF) >>> FRAC_BITS;
    endfunction

    function automatic longint clamp_sat(longint v, longint lo, longint hi, inout bit sat);
        if (v > hi) begin
            sat = 1'b1;
            return hi;
        end
        if (v < lo) begin
            sat = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic t_quat_result compute_quat_result(t_cmd cmd, t_operands op);
        longint       ax, ay, az, aw, bx, by, bz, bw, sf;
        longint       coef [9];
        longint       val [4];
        bit           sat;
        t_quat_result res;
        ax  = op.a_x;
        ay  = op.a_y;
        az  = op.a_z;
        aw  = op.a_w;
        bx  = op.b_x;
        by  = op.b_y;
        bz  = op.b_z;
        bw  = op.b_w;
        sf  = op.scale_factor;
        sat = 1'b0;
        for (int i = 0; i < 4; i++) val[i] = 0;
        case (cmd)
            CMD_MUL: begin
                val[0] = round_prod(ax * bw + bx * aw + ay * bz - az * by);
                val[1] = round_prod(ay * bw + by * aw + az * bx - ax * bz);
                val[2] = round_prod(az * bw + bz * aw + ax * by - ay * bx);
                val[3] = round_prod(aw * bw - ax * bx - ay * by - az * bz);
            end
            CMD_ROT: begin
                // rotation matrix from a, each coefficient rounded and clamped on its own
                coef[0] = ONE_SQ - 2 * (ay * ay + az * az);
                coef[1] = 2 * (ax * ay - aw * az);
                coef[2] = 2 * (ax * az + aw * ay);
                coef[3] = 2 * (ax * ay + aw * az);
                coef[4] = ONE_SQ - 2 * (ax * ax + az * az);
                coef[5] = 2 * (ay * az - aw * ax);
                coef[6] = 2 * (ax * az - aw * ay);
                coef[7] = 2 * (ay * az + aw * ax);
                coef[8] = ONE_SQ - 2 * (ax * ax + ay * ay);
                for (int i = 0; i < 9; i++)
                    coef[i] = clamp_sat(round_prod(coef[i]), -COEF_MAX, COEF_MAX, sat);
                // b_w takes no part, r_w stays zero
                for (int i = 0; i < 3; i++)
                    val[i] = round_prod(coef[3*i] * bx + coef[3*i+1] * by + coef[3*i+2] * bz);
            end
            CMD_ADD: begin
                val[0] = ax + bx;
                val[1] = ay + by;
                val[2] = az + bz;
                val[3] = aw + bw;
            end
            CMD_SUB: begin
                val[0] = ax - bx;
                val[1] = ay - by;
                val[2] = az - bz;
                val[3] = aw - bw;
            end
            CMD_NEG: begin
                val[0] = -ax;
                val[1] = -ay;
                val[2] = -az;
                val[3] = -aw;
            end
            CMD_CONJ: begin
                // w is kept as it is
                val[0] = -ax;
                val[1] = -ay;
                val[2] = -az;
                val[3] = aw;
            end
            CMD_SCALE: begin
                val[0] = round_prod(ax * sf);
                val[1] = round_prod(ay * sf);
                val[2] = round_prod(az * sf);
                val[3] = round_prod(aw * sf);
            end
            CMD_DOT: begin
                // vector part stays zero
                val[3] = round_prod(ax * bx + ay * by + az * bz + aw * bw);
            end
        endcase
        for (int i = 0; i < 4; i++) val[i] = clamp_sat(val[i], CMIN, CMAX, sat);
        res.r_x = COMP_WIDTH'(val[0]);
        res.r_y = COMP_WIDTH'(val[1]);
        res.r_z = COMP_WIDTH'(val[2]);
        res.r_w = COMP_WIDTH'(val[3]);
        res.sat = sat;
        return res;
    endfunction

    function automatic int field_mismatch(string name, longint exp_v, longint got_v);
        if (exp_v != got_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    // predict on the input channel, compare on the output channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && i_s_axis_tready)
                pending_results.push_back(compute_quat_result(t_cmd'(i_s_axis_tuser),
                    t_operands'(i_s_axis_tdata[9*COMP_WIDTH-1:0])));
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got_res = {i_m_axis_tuser, i_m_axis_tdata[4*COMP_WIDTH-1:0]};
                if (pending_results.size() == 0) begin
                    $error("result item with no expectation waiting");
                    fail_count++;
                end else begin
                    exp_res = pending_results.pop_front();
                    fail_count += field_mismatch("r_x", exp_res.r_x, got_res.r_x);
                    fail_count += field_mismatch("r_y", exp_res.r_y, got_res.r_y);
                    fail_count += field_mismatch("r_z", exp_res.r_z, got_res.r_z);
                    fail_count += field_mismatch("r_w", exp_res.r_w, got_res.r_w);
                    fail_count += field_mismatch("saturated", exp_res.sat, got_res.sat);
                end
            end
            pending_count = pending_results.size();
        end
    end

endmodule

### tb/tb_top.sv
// top of the quaternion arithmetic unit testbench: clock, reset, stimulus and verdict
// depends on qau_pkg, quaternion_arithmetic_unit and qau_checker
`timescale 1ns / 100ps

module tb_top;
    import qau_pkg::*;

    localparam int FRAC_BITS  = 14;
    localparam int COMP_WIDTH = 16;
    localparam int IN_W       = ((9*COMP_WIDTH+7)/8)*8;
    localparam int OUT_W      = ((4*COMP_WIDTH+7)/8)*8;
    localparam int OPS_W      = 9*COMP_WIDTH;
    localparam int UNIT       = 1 << FRAC_BITS;
    localparam int RAND_ITEMS = 500;

    localparam logic [COMP_WIDTH-1:0] C_MAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
    localparam logic [COMP_WIDTH-1:0] C_MIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic [CMD_W-1:0] s_tuser = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tuser;
    int               fail_count;
    int               pending;
    int               snd_idle = 15;
    int               rcv_idle = 72;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    quaternion_arithmetic_unit #(
        .FRAC_BITS  (FRAC_BITS),
        .COMP_WIDTH (COMP_WIDTH)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    qau_checker #(
        .FRAC_BITS  (FRAC_BITS),
        .COMP_WIDTH (COMP_WIDTH)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tuser  (m_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // receiver back-pressure
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= rcv_idle);
    end

    // one component: full range, near the unit range, or a corner value
    function automatic logic [COMP_WIDTH-1:0] rand_comp(int mode);
        int pick;
        case (mode)
            0: return COMP_WIDTH'($urandom);
            1: return COMP_WIDTH'(int'($urandom_range(0, 2 * UNIT)) - UNIT);
            default: begin
                pick = $urandom_range(0, 4);
                case (pick)
                    0: return C_MAX;
                    1: return C_MIN;
                    2: return '0;
                    3: return COMP_WIDTH'(UNIT);
                    default: return COMP_WIDTH'(-UNIT);
                endcase
            end
        endcase
    endfunction

    function automatic logic [OPS_W-1:0] rand_operands();
        logic [OPS_W-1:0] ops;
        int               roll;
        int               mode;
        roll = $urandom_range(0, 99);
        mode = (roll < 40) ? 0 : (roll < 85) ? 1 : 2;
        for (int i = 0; i < 9; i++) ops[i*COMP_WIDTH +: COMP_WIDTH] = rand_comp(mode);
        return ops;
    endfunction

    // drive one item after a random gap and hold it until accepted
    task automatic send_item(input t_cmd cmd, input logic [OPS_W-1:0] ops);
        while ($urandom_range(0, 99) < snd_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'(ops);
        s_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    initial begin
        t_cmd cmd;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corners for every operation: all max, all min, a at max against b and scale at min
        for (int c = 0; c < 8; c++) begin
            cmd = t_cmd'(c);
            send_item(cmd, {9{C_MAX}});
            send_item(cmd, {9{C_MIN}});
            send_item(cmd, {{5{C_MIN}}, {4{C_MAX}}});
        end
        // identity rotation of a plain vector, operand order from scale_factor down to a_x
        send_item(CMD_ROT, {16'sd0, 16'sd0, 16'sd3000, -16'sd2000, 16'sd1000,
                            COMP_WIDTH'(UNIT), 16'sd0, 16'sd0, 16'sd0});

        // three idling phases of random items
        for (int phase = 0; phase < 3; phase++) begin
            snd_idle = (phase == 0) ? 15 : (phase == 1) ? 72 : 0;
            rcv_idle = (phase == 0) ? 72 : (phase == 1) ? 15 : 0;
            for (int n = 0; n < RAND_ITEMS; n++)
                send_item(t_cmd'($urandom_range(0, 7)), rand_operands());
        end
        s_tvalid <= 1'b0;

        // drain, then let the pipeline settle
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // run time limit
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
